@@ rtl/bfir_pkg.sv @@
package bfir_pkg;

   localparam int CFG_W       = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_W     = 8;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 32;
   localparam int COUNT_W     = 17;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int EXT_W       = 10;
   localparam int NUM_W       = 18;

   // shared divider: long ops cover channel sums, short ops cover window math
   localparam int DIVIDEND_W  = 26;
   localparam int DIVISOR_W   = 18;
   localparam int SHORT_W     = 17;
   localparam int ITER_W      = 5;

   localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_TARGET_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_COL_FIRST = 3'd0,
      OP_COL_EXT   = 3'd1,
      OP_ROW_FIRST = 3'd2,
      OP_ROW_EXT   = 3'd3,
      OP_RED       = 3'd4,
      OP_GREEN     = 3'd5,
      OP_BLUE      = 3'd6,
      OP_ALPHA     = 3'd7
   } div_op_type;

   typedef struct packed {
      logic                  start;
      logic                  long_mode;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/bfir_ram.sv @@
module bfir_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bfir_divider.sv @@
module bfir_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  bfir_pkg::div_req_type req,
   output bfir_pkg::div_rsp_type rsp
);
   import bfir_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ITER_W-1:0]     count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = req.divisor;
         if (req.long_mode) begin
            quo_in   = req.dividend;
            count_in = ITER_W'(DIVIDEND_W);
         end else begin
            quo_in   = {req.dividend[SHORT_W-1:0], {(DIVIDEND_W-SHORT_W){1'b0}}};
            count_in = ITER_W'(SHORT_W);
         end
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - ITER_W'(1);
         if (count_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   done_ends_busy_a: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");

   start_only_idle_a: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   remainder_below_divisor_a: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !req.start |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

endmodule

@@ rtl/box_filter_image_resample_unit.sv @@
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser: kind; tdata: col,row,red,green,blue,alpha
// rsp     | out | rsp_tvalid/rsp_tready | tdata: red,green,blue,alpha,sample_count
// csr     | in  | csr_we                | csr_index, csr_wdata
// A load is written straight to the frame store when it is taken.
// A request uses four 17-step and four 26-step runs of the one radix-2 divider,
// plus one frame store read per window pixel.
// Reset is synchronous; the frame store is not cleared, sizes return to 256.
// The result sits in an output register; loads are taken while it waits, a further
// request stalls at its end until the register is free.
module box_filter_image_resample_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // col, row, red, green, blue, alpha
   input  logic [bfir_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // red, green, blue, alpha, sample_count, zero fill
   output logic [bfir_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [bfir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfir_pkg::CFG_W-1:0]         csr_wdata
);
   import bfir_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DIV_START = 7'b0000010,
      ST_DIV_WAIT  = 7'b0000100,
      ST_SETUP     = 7'b0001000,
      ST_SCAN      = 7'b0010000,
      ST_DRAIN     = 7'b0100000,
      ST_RESULT    = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   div_op_type                     op_ff, op_in;
   logic [CFG_W-1:0]               src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [COORD_W-1:0]             col_req_ff, col_req_in, row_req_ff, row_req_in;
   logic [CFG_W-1:0]               c0_ff, c0_in, r0_ff, r0_in;
   logic [EXT_W-1:0]               ext_c_ff, ext_c_in, ext_r_ff, ext_r_in;
   logic [CFG_W-1:0]               cn_ff, cn_in, rn_ff, rn_in;
   logic [CFG_W-1:0]               col_ff, col_in;
   logic [CFG_W-1:0]               cols_left_ff, cols_left_in, rows_left_ff, rows_left_in;
   logic [AW-1:0]                  row_base_ff, row_base_in;
   logic                           pend_ff, pend_in;
   logic [3:0][DIVIDEND_W-1:0]     sum_ff, sum_in;
   logic [3:0][CHAN_W-1:0]         avg_ff, avg_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]          rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0]   sw, sh, tw, th;
   logic [CFG_W-1:0]   span_c, span_r, cn_w, rn_w;
   logic [NUM_W-1:0]   n_w;
   logic [COORD_W-1:0] req_col, req_row;
   logic               req_fire, req_hit, load_in_range;
   logic               mem_we;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   logic [PIXEL_W-1:0] mem_rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_col  = req_tdata[7:0];
   assign req_row  = req_tdata[15:8];
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      sw = (src_w_ff == '0) ? CFG_W'(1) :
           (32'(src_w_ff) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : src_w_ff;
      sh = (src_h_ff == '0) ? CFG_W'(1) :
           (32'(src_h_ff) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : src_h_ff;
      tw = (dst_w_ff == '0) ? CFG_W'(1) : dst_w_ff;
      th = (dst_h_ff == '0) ? CFG_W'(1) : dst_h_ff;
   end

   assign req_hit       = ({1'b0, req_col} < tw) && ({1'b0, req_row} < th);
   assign load_in_range = (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign mem_we        = req_fire && (req_tuser == KIND_LOAD) && load_in_range;
   assign mem_wr_addr   = AW'(32'(req_row) * MAX_WIDTH + 32'(req_col));
   assign mem_rd_addr   = AW'(32'(row_base_ff) + 32'(col_ff));

   // window extent per axis: min(ceil(src/dst), src - first)
   assign span_c = sw - c0_ff;
   assign span_r = sh - r0_ff;
   assign cn_w   = ({1'b0, span_c} < ext_c_ff) ? span_c : ext_c_ff[CFG_W-1:0];
   assign rn_w   = ({1'b0, span_r} < ext_r_ff) ? span_r : ext_r_ff[CFG_W-1:0];
   assign n_w    = NUM_W'(cn_ff) * NUM_W'(rn_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SIZE_RESET;
         src_h_ff <= SIZE_RESET;
         dst_w_ff <= SIZE_RESET;
         dst_h_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:  src_w_ff <= csr_wdata;
            CSR_SOURCE_HEIGHT: src_h_ff <= csr_wdata;
            CSR_TARGET_WIDTH:  dst_w_ff <= csr_wdata;
            CSR_TARGET_HEIGHT: dst_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      div_req.start     = (state_ff == ST_DIV_START);
      div_req.long_mode = 1'b1;
      div_req.dividend  = '0;
      div_req.divisor   = DIVISOR_W'(n_w);
      case (op_ff)
         OP_COL_FIRST: begin
            div_req.long_mode = 1'b0;
            div_req.dividend  = DIVIDEND_W'(col_req_ff) * DIVIDEND_W'(sw);
            div_req.divisor   = DIVISOR_W'(tw);
         end
         OP_COL_EXT: begin
            div_req.long_mode = 1'b0;
            div_req.dividend  = DIVIDEND_W'(sw) + DIVIDEND_W'(tw) - DIVIDEND_W'(1);
            div_req.divisor   = DIVISOR_W'(tw);
         end
         OP_ROW_FIRST: begin
            div_req.long_mode = 1'b0;
            div_req.dividend  = DIVIDEND_W'(row_req_ff) * DIVIDEND_W'(sh);
            div_req.divisor   = DIVISOR_W'(th);
         end
         OP_ROW_EXT: begin
            div_req.long_mode = 1'b0;
            div_req.dividend  = DIVIDEND_W'(sh) + DIVIDEND_W'(th) - DIVIDEND_W'(1);
            div_req.divisor   = DIVISOR_W'(th);
         end
         OP_RED:   div_req.dividend = sum_ff[0];
         OP_GREEN: div_req.dividend = sum_ff[1];
         OP_BLUE:  div_req.dividend = sum_ff[2];
         OP_ALPHA: div_req.dividend = sum_ff[3];
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      col_req_in   = col_req_ff;
      row_req_in   = row_req_ff;
      c0_in        = c0_ff;
      r0_in        = r0_ff;
      ext_c_in     = ext_c_ff;
      ext_r_in     = ext_r_ff;
      cn_in        = cn_ff;
      rn_in        = rn_ff;
      col_in       = col_ff;
      cols_left_in = cols_left_ff;
      rows_left_in = rows_left_ff;
      row_base_in  = row_base_ff;
      pend_in      = (state_ff == ST_SCAN);
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (pend_ff) begin
         for (int k = 0; k < 4; k++) begin
            sum_in[k] = sum_ff[k] + DIVIDEND_W'(mem_rd_data[k*CHAN_W +: CHAN_W]);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_REQUEST) && req_hit) begin
               col_req_in = req_col;
               row_req_in = req_row;
               op_in      = OP_COL_FIRST;
               state_in   = ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_COL_FIRST: c0_in     = div_rsp.quotient[CFG_W-1:0];
                  OP_COL_EXT:   ext_c_in  = div_rsp.quotient[EXT_W-1:0];
                  OP_ROW_FIRST: r0_in     = div_rsp.quotient[CFG_W-1:0];
                  OP_ROW_EXT:   ext_r_in  = div_rsp.quotient[EXT_W-1:0];
                  OP_RED:       avg_in[0] = div_rsp.quotient[CHAN_W-1:0];
                  OP_GREEN:     avg_in[1] = div_rsp.quotient[CHAN_W-1:0];
                  OP_BLUE:      avg_in[2] = div_rsp.quotient[CHAN_W-1:0];
                  OP_ALPHA:     avg_in[3] = div_rsp.quotient[CHAN_W-1:0];
                  default: ;
               endcase
               op_in = div_op_type'(op_ff + 3'd1);
               if (op_ff == OP_ROW_EXT) begin
                  state_in = ST_SETUP;
               end else if (op_ff == OP_ALPHA) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_SETUP: begin
            cn_in        = cn_w;
            rn_in        = rn_w;
            col_in       = c0_ff;
            cols_left_in = cn_w - CFG_W'(1);
            rows_left_in = rn_w - CFG_W'(1);
            row_base_in  = AW'(32'(r0_ff) * MAX_WIDTH);
            sum_in       = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (cols_left_ff == '0) begin
               if (rows_left_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  col_in       = c0_ff;
                  cols_left_in = cn_ff - CFG_W'(1);
                  rows_left_in = rows_left_ff - CFG_W'(1);
                  row_base_in  = AW'(32'(row_base_ff) + MAX_WIDTH);
               end
            end else begin
               col_in       = col_ff + CFG_W'(1);
               cols_left_in = cols_left_ff - CFG_W'(1);
            end
         end
         ST_DRAIN: state_in = ST_DIV_START;
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-PIXEL_W-COUNT_W){1'b0}}, n_w[COUNT_W-1:0],
                               avg_ff[3], avg_ff[2], avg_ff[1], avg_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_COL_FIRST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_req_ff   <= col_req_in;
      row_req_ff   <= row_req_in;
      c0_ff        <= c0_in;
      r0_ff        <= r0_in;
      ext_c_ff     <= ext_c_in;
      ext_r_ff     <= ext_r_in;
      cn_ff        <= cn_in;
      rn_ff        <= rn_in;
      col_ff       <= col_in;
      cols_left_ff <= cols_left_in;
      rows_left_ff <= rows_left_in;
      row_base_ff  <= row_base_in;
      sum_ff       <= sum_in;
      avg_ff       <= avg_in;
      rsp_data_ff  <= rsp_data_in;
   end

   bfir_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH),
      .ADDR_W(AW)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wr_addr),
      .wr_data(req_tdata[47:16]),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   bfir_divider u_divider (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   idle_divider_quiet_a: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_rsp.busy)
      else $error("divider busy while taking transactions");

   done_only_waiting_a: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider result with no consumer");

   read_follows_scan_a: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_SCAN))
      else $error("frame store data accumulated outside a scan");

   count_nonzero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:32] != '0)
      else $error("result with zero samples");

endmodule

@@ tb/sv/box_filter_image_resample_unit_test.sv @@
module box_filter_image_resample_unit_test;
   import bfir_pkg::*;

   localparam int MAX_W         = 256;
   localparam int MAX_H         = 256;
   localparam int TARGET_MAX    = 511;
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES   = 3000;
   localparam int ITEM_GOAL     = 1250;

   typedef struct {
      logic               kind;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
   } resample_item_type;

   typedef struct {
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      logic [COUNT_W-1:0] count;
   } averaged_pixel_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // col, row, red, green, blue, alpha
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // kind
   logic                   req_tuser  = KIND_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // red, green, blue, alpha, sample_count, zero fill
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_SOURCE_WIDTH;
   logic [CFG_W-1:0]       csr_wdata  = '0;

   box_filter_image_resample_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the block state
   logic [PIXEL_W-1:0] shadow_store [0:MAX_W*MAX_H-1];
   logic [CFG_W-1:0]   size_reg [4] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET, SIZE_RESET};

   resample_item_type  pixel_items [$];
   averaged_pixel_type averaged_pixels [$];

   // generation side: which store entries have been loaded so far
   bit loaded [0:MAX_W*MAX_H-1];
   int unsigned gen_sw, gen_sh, gen_tw, gen_th;
   int item_total = 0;
   int settings_done = 0;

   int mismatches = 0;
   int loads_sent = 0;
   int requests_sent = 0;
   int results_seen = 0;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void axis_window(input int unsigned idx, input int unsigned src,
                                       input int unsigned dst, output int unsigned first,
                                       output int unsigned span);
      int unsigned ext;
      int unsigned last;
      first = (idx * src) / dst;
      ext   = (src + dst - 1) / dst;
      last  = first + ext - 1;
      if (last >= src) last = src - 1;
      span = last - first + 1;
   endfunction

   function automatic bit average_window(input resample_item_type it,
                                         output averaged_pixel_type px);
      int unsigned sw, sh, tw, th, c0, cn, r0, rn, n;
      int unsigned sum [4];
      logic [PIXEL_W-1:0] word;
      sw = clamp_size(32'(size_reg[CSR_SOURCE_WIDTH]), MAX_W);
      sh = clamp_size(32'(size_reg[CSR_SOURCE_HEIGHT]), MAX_H);
      tw = clamp_size(32'(size_reg[CSR_TARGET_WIDTH]), TARGET_MAX);
      th = clamp_size(32'(size_reg[CSR_TARGET_HEIGHT]), TARGET_MAX);
      px = '{default: '0};
      if (32'(it.col) >= tw || 32'(it.row) >= th) return 0;
      axis_window(32'(it.col), sw, tw, c0, cn);
      axis_window(32'(it.row), sh, th, r0, rn);
      sum = '{0, 0, 0, 0};
      for (int unsigned r = r0; r < r0 + rn; r++) begin
         for (int unsigned c = c0; c < c0 + cn; c++) begin
            word = shadow_store[r * MAX_W + c];
            sum[0] += 32'(word[7:0]);
            sum[1] += 32'(word[15:8]);
            sum[2] += 32'(word[23:16]);
            sum[3] += 32'(word[31:24]);
         end
      end
      n = cn * rn;
      px.red   = CHAN_W'(sum[0] / n);
      px.green = CHAN_W'(sum[1] / n);
      px.blue  = CHAN_W'(sum[2] / n);
      px.alpha = CHAN_W'(sum[3] / n);
      px.count = COUNT_W'(n);
      return 1;
   endfunction

   function automatic void apply_item(input resample_item_type it);
      averaged_pixel_type px;
      if (it.kind == KIND_LOAD) begin
         shadow_store[32'(it.row) * MAX_W + 32'(it.col)] = {it.alpha, it.blue, it.green, it.red};
         loads_sent++;
      end else begin
         requests_sent++;
         if (average_window(it, px)) averaged_pixels.push_back(px);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // ---------------- driver ----------------
   resample_item_type cur_item;
   int burst_left = 0;
   int gap_left = 0;

   function automatic logic [REQ_DATA_W-1:0] pack_item(input resample_item_type it);
      return {it.alpha, it.blue, it.green, it.red, it.row, it.col};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (req_tvalid && req_tready) begin
         apply_item(cur_item);
         if (burst_left > 0 && pixel_items.size() > 0) begin
            cur_item = pixel_items.pop_front();
            req_tdata <= pack_item(cur_item);
            req_tuser <= cur_item.kind;
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else if (!req_tvalid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_items.size() > 0) begin
            cur_item = pixel_items.pop_front();
            req_tdata  <= pack_item(cur_item);
            req_tuser  <= cur_item.kind;
            req_tvalid <= 1'b1;
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 15);
         end
      end
   end

   // ---------------- monitor ----------------
   averaged_pixel_type want_px;
   int hold_left = 0;
   bit hold_done = 0;
   int stall_mode = 0;
   int mon_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (averaged_pixels.size() == 0) begin
               report_mismatch("result with nothing pending", 32'(rsp_tdata[48:32]), 0);
            end else begin
               want_px = averaged_pixels.pop_front();
               if (rsp_tdata[7:0] !== want_px.red)
                  report_mismatch("red", 32'(rsp_tdata[7:0]), 32'(want_px.red));
               if (rsp_tdata[15:8] !== want_px.green)
                  report_mismatch("green", 32'(rsp_tdata[15:8]), 32'(want_px.green));
               if (rsp_tdata[23:16] !== want_px.blue)
                  report_mismatch("blue", 32'(rsp_tdata[23:16]), 32'(want_px.blue));
               if (rsp_tdata[31:24] !== want_px.alpha)
                  report_mismatch("alpha", 32'(rsp_tdata[31:24]), 32'(want_px.alpha));
               if (rsp_tdata[48:32] !== want_px.count)
                  report_mismatch("sample_count", 32'(rsp_tdata[48:32]),
                                  32'(want_px.count));
               if (rsp_tdata[55:49] !== '0)
                  report_mismatch("zero fill", 32'(rsp_tdata[55:49]), 0);
            end
         end
         mon_cycle++;
         if (mon_cycle % 256 == 0) stall_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 100 && pixel_items.size() >= 20) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("box_filter_image_resample_unit test failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic queue_load(input int col, input int row, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                             input logic [CHAN_W-1:0] a);
      resample_item_type it;
      it.kind  = KIND_LOAD;
      it.col   = COORD_W'(col);
      it.row   = COORD_W'(row);
      it.red   = r;
      it.green = g;
      it.blue  = b;
      it.alpha = a;
      pixel_items.push_back(it);
      loaded[row * MAX_W + col] = 1;
      item_total++;
   endtask

   task automatic queue_random_load(input int col, input int row);
      queue_load(col, row, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                 CHAN_W'($urandom));
   endtask

   task automatic queue_request(input int col, input int row);
      resample_item_type it;
      it.kind  = KIND_REQUEST;
      it.col   = COORD_W'(col);
      it.row   = COORD_W'(row);
      it.red   = CHAN_W'($urandom);
      it.green = CHAN_W'($urandom);
      it.blue  = CHAN_W'($urandom);
      it.alpha = CHAN_W'($urandom);
      pixel_items.push_back(it);
      item_total++;
   endtask

   task automatic wait_idle();
      while (pixel_items.size() > 0 || req_tvalid || averaged_pixels.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      size_reg[idx] = v;
   endtask

   task automatic set_sizes(input int sw, input int sh, input int tw, input int th);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_SOURCE_WIDTH, CFG_W'(sw));
      write_csr(CSR_SOURCE_HEIGHT, CFG_W'(sh));
      write_csr(CSR_TARGET_WIDTH, CFG_W'(tw));
      write_csr(CSR_TARGET_HEIGHT, CFG_W'(th));
      @(posedge clock);
      csr_we <= 1'b0;
      settings_done++;
      gen_sw = clamp_size(sw, MAX_W);
      gen_sh = clamp_size(sh, MAX_H);
      gen_tw = clamp_size(tw, TARGET_MAX);
      gen_th = clamp_size(th, TARGET_MAX);
      // every window of this setting must read loaded pixels only
      for (int r = 0; r < gen_sh; r++)
         for (int c = 0; c < gen_sw; c++)
            if (!loaded[r * MAX_W + c]) queue_random_load(c, r);
   endtask

   task automatic queue_random_items(input int n);
      int sel;
      int col_hi;
      int row_hi;
      col_hi = (gen_tw > MAX_W) ? MAX_W - 1 : gen_tw - 1;
      row_hi = (gen_th > MAX_H) ? MAX_H - 1 : gen_th - 1;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            if ($urandom_range(0, 2) != 0)
               queue_random_load($urandom_range(0, gen_sw - 1), $urandom_range(0, gen_sh - 1));
            else
               queue_random_load($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1));
         end else if (sel < 88) begin
            queue_request($urandom_range(0, col_hi), $urandom_range(0, row_hi));
         end else begin
            queue_request($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1));
         end
      end
   endtask

   int rsw, rsh, rtw, rth;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset sizes, one-to-one copy at the image corners
      queue_load(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_load(255, 255, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_load(255, 0, 8'hFF, 8'h00, 8'hFF, 8'h00);
      queue_load(0, 255, 8'h00, 8'hFF, 8'h00, 8'hFF);
      queue_load(128, 64, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
      queue_request(0, 0);
      queue_request(255, 255);
      queue_request(255, 0);
      queue_request(0, 255);
      queue_request(128, 64);
      queue_load(0, 0, 8'h01, 8'h80, 8'h7F, 8'hFE);
      queue_request(0, 0);

      set_sizes(4, 4, 2, 2);
      queue_random_items(30);
      set_sizes(0, 0, 0, 0);          // sizes below one clamp to one
      queue_random_items(20);
      set_sizes(511, 1, 1, 1);        // source width clamps to the maximum
      queue_random_items(20);
      set_sizes(1, 511, 1, 300);      // tall source, rows upscaled
      queue_random_items(40);
      set_sizes(5, 7, 3, 2);
      queue_random_items(30);
      set_sizes(3, 3, 8, 8);          // upscaling both axes
      queue_random_items(30);
      set_sizes(2, 2, 511, 511);
      queue_random_items(30);
      set_sizes(256, 1, 7, 3);
      queue_random_items(30);

      while (item_total < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0: rsw = 0;
            default: rsw = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 9))
            0: rsh = 0;
            default: rsh = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 9))
            0: rtw = 0;
            1: rtw = $urandom_range(257, TARGET_MAX);
            default: rtw = $urandom_range(1, 20);
         endcase
         case ($urandom_range(0, 9))
            0: rth = 0;
            1: rth = $urandom_range(257, TARGET_MAX);
            default: rth = $urandom_range(1, 20);
         endcase
         set_sizes(rsw, rsh, rtw, rth);
         queue_random_items($urandom_range(30, 80));
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (averaged_pixels.size() != 0)
         report_mismatch("results never delivered", 0, averaged_pixels.size());

      $display("covered %0d loads and %0d requests over %0d size settings",
               loads_sent, requests_sent, settings_done + 1);
      $display("%0d averaged pixels checked, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("box_filter_image_resample_unit test passed");
      end else begin
         $display("box_filter_image_resample_unit test failed");
      end
      $finish;
   end

endmodule
